### hdl/shi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package shi_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Operation codes
    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_DEL  = 2'd1;
    localparam logic [1:0] FUNC_FIND = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_DELETED   = 3'd2,
        STAT_ABSENT    = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_MATCH     = 3'd5
    } status_t;

    // One table row
    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] uid;
        logic [31:0] id;
    } entry_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_PROBE,
        S_SHR,
        S_SHW,
        S_INS,
        S_RESP,
        S_FIND
    } state_t;

endpackage

`default_nettype wire

### hdl/shi_table_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module shi_table_ram
    import shi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [TABLE_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/sorted_hash_uid_index_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted index of up to 64 entries keyed by (guid_hash, local_uid), each carrying
// an entry id. Items are taken one at a time: in_ready is high only while the block
// is idle. Every add, delete or find starts with a binary search over the stored entries on
// one single-port-read table memory, each probe a read, then a compare. An add then
// moves every entry above the insertion point up by one and a delete moves every entry
// above the hit down by one, each moved entry a read, then a write, through the same port.
// A find streams one match per cycle once the search lands, while the output is accepted;
// the last match is flagged, and a find with no match gives a single not-present result.
// Results leave through a one-item output register, so the next item can be accepted
// while the final result of the previous one waits. No clearing pass after reset.
module sorted_hash_uid_index_top
    import shi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] guid_hash,
    input  wire logic [31:0] local_uid,
    input  wire logic [31:0] entry_id,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      found_entry_id,
    output logic             last
);

    state_t            state_reg, state_next;
    logic [1:0]        func_reg, func_next;
    logic [31:0]       hash_reg, hash_next;
    logic [31:0]       uid_reg, uid_next;
    logic [31:0]       id_reg, id_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           res_reg, res_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [31:0]       pend_id_reg, pend_id_next;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [31:0]       out_id_reg;
    logic              out_last_reg;

    // Table memory port
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    // Result emission
    logic              emit;
    status_t           emit_status;
    logic [31:0]       emit_id;
    logic              emit_last;

    // Shared compare unit and cursor arithmetic
    logic              in_acc;
    logic              out_free;
    logic              func_known;
    logic              lo_lt_hi;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid;
    logic              key_below;
    logic              hash_hit;
    logic              key_hit;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  idx_dec;
    logic              is_full;
    logic              shift_more;

    shi_table_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        in_acc     = in_valid & in_ready;
        out_free   = !out_valid_reg || out_ready;
        func_known = func inside {FUNC_ADD, FUNC_DEL, FUNC_FIND};
        lo_lt_hi   = lo_reg < hi_reg;
        mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid        = mid_sum[CNT_W:1];
        key_below  = (rd_data.hash < hash_reg) ||
                     ((rd_data.hash == hash_reg) && (rd_data.uid < uid_reg));
        hash_hit   = (idx_reg < count_reg) && (rd_data.hash == hash_reg);
        key_hit    = hash_hit && (rd_data.uid == uid_reg);
        idx_inc    = idx_reg + CNT_W'(1);
        idx_dec    = idx_reg - CNT_W'(1);
        is_full    = count_reg == CNT_W'(TABLE_DEPTH);
        shift_more = (func_reg == FUNC_ADD) ? (idx_reg > lo_reg) : (idx_inc < count_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = func_known ? S_SRCH : S_RESP;
                end
            end
            S_SRCH:
            begin
                if (lo_lt_hi)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = (func_reg == FUNC_FIND) ? S_FIND : S_PROBE;
                end
            end
            S_CMP:
            begin
                state_next = S_SRCH;
            end
            S_PROBE:
            begin
                if (func_reg == FUNC_ADD)
                begin
                    state_next = (key_hit || is_full) ? S_RESP : S_SHR;
                end
                else
                begin
                    state_next = key_hit ? S_SHR : S_RESP;
                end
            end
            S_SHR:
            begin
                if (shift_more)
                begin
                    state_next = S_SHW;
                end
                else
                begin
                    state_next = (func_reg == FUNC_ADD) ? S_INS : S_RESP;
                end
            end
            S_SHW:
            begin
                state_next = S_SHR;
            end
            S_INS:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIND:
            begin
                if (!hash_hit && out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath control and result emission
    always_comb
    begin
        in_ready        = 1'b0;
        func_next       = func_reg;
        hash_next       = hash_reg;
        uid_next        = uid_reg;
        id_next         = id_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[ADDR_W-1:0];
        wr_data         = rd_data;
        emit            = 1'b0;
        emit_status     = res_reg;
        emit_id         = '0;
        emit_last       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_acc)
                begin
                    func_next       = func;
                    hash_next       = guid_hash;
                    uid_next        = (func == FUNC_FIND) ? '0 : local_uid;
                    id_next         = entry_id;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    res_next        = STAT_ABSENT;
                    pend_valid_next = 1'b0;
                end
            end
            // Binary search: issue probe at midpoint, or land at lower bound
            S_SRCH:
            begin
                if (lo_lt_hi)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = mid[ADDR_W-1:0];
                    idx_next = mid;
                end
                else
                begin
                    idx_next = lo_reg;
                    if (lo_reg < count_reg)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = lo_reg[ADDR_W-1:0];
                    end
                end
            end
            S_CMP:
            begin
                if (key_below)
                begin
                    lo_next = idx_inc;
                end
                else
                begin
                    hi_next = idx_reg;
                end
            end
            // Entry at lower bound decides add / delete outcome
            S_PROBE:
            begin
                if (func_reg == FUNC_ADD)
                begin
                    if (key_hit)
                    begin
                        res_next = STAT_DUPLICATE;
                    end
                    else if (is_full)
                    begin
                        res_next = STAT_FULL;
                    end
                    else
                    begin
                        idx_next = count_reg;
                    end
                end
                else if (!key_hit)
                begin
                    res_next = STAT_ABSENT;
                end
            end
            // Shift read: add walks down from the top, delete walks up from the hit
            S_SHR:
            begin
                if (shift_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = (func_reg == FUNC_ADD) ? idx_dec[ADDR_W-1:0]
                                                     : idx_inc[ADDR_W-1:0];
                end
                else if (func_reg == FUNC_DEL)
                begin
                    count_next = count_reg - CNT_W'(1);
                    res_next   = STAT_DELETED;
                end
            end
            S_SHW:
            begin
                wr_en    = 1'b1;
                idx_next = (func_reg == FUNC_ADD) ? idx_dec : idx_inc;
            end
            S_INS:
            begin
                wr_en        = 1'b1;
                wr_addr      = lo_reg[ADDR_W-1:0];
                wr_data.hash = hash_reg;
                wr_data.uid  = uid_reg;
                wr_data.id   = id_reg;
                count_next   = count_reg + CNT_W'(1);
                res_next     = STAT_INSERTED;
            end
            S_RESP:
            begin
                emit = out_free;
            end
            // Find: one match held back so the final one can carry last
            S_FIND:
            begin
                if (hash_hit)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        emit            = pend_valid_reg;
                        emit_status     = STAT_MATCH;
                        emit_id         = pend_id_reg;
                        emit_last       = 1'b0;
                        pend_id_next    = rd_data.id;
                        pend_valid_next = 1'b1;
                        idx_next        = idx_inc;
                        if (idx_inc < count_reg)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = idx_inc[ADDR_W-1:0];
                        end
                    end
                end
                else if (out_free)
                begin
                    emit            = 1'b1;
                    emit_status     = pend_valid_reg ? STAT_MATCH : STAT_ABSENT;
                    emit_id         = pend_valid_reg ? pend_id_reg : '0;
                    emit_last       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        hash_reg    <= hash_next;
        uid_reg     <= uid_next;
        id_reg      <= id_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        idx_reg     <= idx_next;
        res_reg     <= res_next;
        pend_id_reg <= pend_id_next;
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_id_reg     <= emit_id;
            out_last_reg   <= emit_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign found_entry_id = out_id_reg;
    assign last           = out_last_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ((count_reg == $past(count_reg) + CNT_W'(1)) ||
         (count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("entry count moved by more than one");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result overwrote an unaccepted item");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken before first finished");

endmodule

`default_nettype wire
